// ===== hw/rtl/pidc_pkg.sv =====
// Shared widths, register indexes and the sequencer state type of the clamped PID block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pidc_pkg;

	localparam int DATA_W    = 32;
	localparam int DT_W      = 16;
	localparam int CFG_IDX_W = 3;

	// serial multiplier: magnitude operands, one multiplier bit per cycle
	localparam int MA_W = 40;
	localparam int MB_W = 32;
	localparam int MP_W = MA_W + MB_W;

	// serial divider: one quotient bit per cycle
	localparam int DVD_W = 64;
	localparam int DVS_W = 26;

	localparam int GAIN_FRAC = 24;  // Q8.24 gains
	localparam int ERR_FRAC  = 16;  // Q16.16 error

	localparam logic [DVS_W-1:0] ERR_DIV            = DVS_W'(1000);
	localparam logic [DT_W-1:0]  FIXED_INTERVAL_RST = DT_W'(40);

	localparam logic [CFG_IDX_W-1:0] REG_KP             = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KI             = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KD             = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX        = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN        = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_USE_FIXED      = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_INTERVAL = CFG_IDX_W'(6);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_MULP,
		ST_MULI,
		ST_MULT,
		ST_MULD,
		ST_DIVD,
		ST_SUM
	} state_t;

endpackage

// ===== hw/rtl/pidc_mul.sv =====
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pidc_pkg for operand widths.
`timescale 1ns / 1ps

module pidc_mul import pidc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MA_W-1:0] a,
	input  logic [MB_W-1:0] b,
	output logic            done,
	output logic [MP_W-1:0] prod
);

	localparam int CNT_W = $clog2(MB_W);

	logic [MA_W-1:0]  a_q;
	logic [MP_W-1:0]  prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MA_W:0]    psum;

	// upper half accumulates, lower half shifts the multiplier out
	assign psum = {1'b0, prod_q[MP_W-1:MB_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{MA_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {psum, prod_q[MB_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ===== hw/rtl/pidc_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pidc_pkg for operand widths; divisor must be nonzero.
`timescale 1ns / 1ps

module pidc_div import pidc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   shl;
	logic [DVS_W:0]   trial;

	assign shl   = {rem_q, quo_q[DVD_W-1]};
	assign trial = shl - {1'b0, dvs_q};  // top bit set means borrow

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= trial[DVS_W] ? shl[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ~trial[DVS_W]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/pid_controller_clamped.sv =====
// PID controller with integral clamp: an update item takes a raw error (scaled by 1/1000 into
// Q16.16) and an interval, and returns one saturated drive value; a reset item clears the
// integral, the last error and re-arms the first-step flag, and returns nothing.
// The work runs on one bit-serial divider (64 quotient bits) and one bit-serial multiplier
// (32 multiplier bits). An update scales the error and multiplies by kp; on the first step
// after a reset it then sums, otherwise it multiplies by ki and the interval and, unless the
// interval is zero, by kd and then divides. The next item is taken as soon as the result is in
// the output register. Configuration is to be written by the user only while the block is
// idle; the block does not enforce it. Depends on pidc_pkg, pidc_mul and pidc_div.
`timescale 1ns / 1ps

module pid_controller_clamped import pidc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [DATA_W-1:0]        cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] error_raw,
	input  logic [DT_W-1:0]          elapsed,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] drive
);

	localparam int STEP_W = 55;          // integral step width, ki*e*dt/2
	localparam int SUM_W  = MA_W + 2;
	localparam int SH_W   = DVD_W - GAIN_FRAC + 1;
	localparam int DTOP_W = DVD_W - GAIN_FRAC - DATA_W + 2;
	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? (~x + 1'b1) : x;
	endfunction

	// configuration
	logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, out_max_q, out_min_q;
	logic                     use_fixed_q;
	logic [DT_W-1:0]          fixed_q;

	// loop state
	logic signed [DATA_W-1:0] integ_q, last_q, deriv_q;
	logic                     first_q;

	// working registers
	state_t                   state_q, state_d;
	logic                     new_q;
	logic signed [DATA_W-1:0] er_q, e_q;
	logic [DT_W-1:0]          dt_q;
	logic signed [MA_W-1:0]   p_q, ist_q;
	logic                     dneg_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;

	// serial units
	logic             mul_go, mul_done, div_go, div_done;
	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic [MP_W-1:0]  mul_prod;
	logic [DVD_W-1:0] div_dvd, div_quo;
	logic [DVS_W-1:0] div_dvs;
	logic             mneg;
	logic             load_out;

	// datapath
	logic [DATA_W-1:0]        kp_mag, ki_mag, kd_mag, e_mag, er_mag, diff_mag;
	logic signed [DATA_W:0]   diff;
	logic [DATA_W:0]          diff_abs;
	logic [MA_W-1:0]          ist_mag;
	logic signed [DVD_W:0]    sprod, squo;
	logic signed [MA_W-1:0]   p_new;
	logic signed [STEP_W-1:0] step;
	logic signed [STEP_W:0]   acc;
	logic signed [DATA_W-1:0] hi_half, lo_half, integ_new, e_new, deriv_new, drive_new;
	logic signed [SH_W-1:0]   dsh;
	logic [DTOP_W-1:0]        dtop;
	logic signed [SUM_W-1:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			out_max_q   <= SAT_MAX;
			out_min_q   <= SAT_MIN;
			use_fixed_q <= 1'b0;
			fixed_q     <= FIXED_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KP:             kp_q        <= cfg_wdata;
				REG_KI:             ki_q        <= cfg_wdata;
				REG_KD:             kd_q        <= cfg_wdata;
				REG_OUT_MAX:        out_max_q   <= cfg_wdata;
				REG_OUT_MIN:        out_min_q   <= cfg_wdata;
				REG_USE_FIXED:      use_fixed_q <= cfg_wdata[0];
				REG_FIXED_INTERVAL: fixed_q     <= cfg_wdata[DT_W-1:0];
				default: ;
			endcase
		end
	end

	assign kp_mag   = mag32(kp_q);
	assign ki_mag   = mag32(ki_q);
	assign kd_mag   = mag32(kd_q);
	assign e_mag    = mag32(e_q);
	assign er_mag   = mag32(er_q);
	assign diff     = (DATA_W+1)'(e_q) - (DATA_W+1)'(last_q);
	assign diff_abs = diff[DATA_W] ? -diff : diff;
	assign diff_mag = diff_abs[DATA_W-1:0];
	assign ist_mag  = ist_q[MA_W-1] ? -ist_q : ist_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mneg  = 1'b0;
		case (state_q)
			ST_MULP: begin
				mul_a = MA_W'(kp_mag);
				mul_b = e_mag;
				mneg  = kp_q[DATA_W-1] ^ e_q[DATA_W-1];
			end
			ST_MULI: begin
				mul_a = MA_W'(ki_mag);
				mul_b = e_mag;
				mneg  = ki_q[DATA_W-1] ^ e_q[DATA_W-1];
			end
			ST_MULT: begin
				mul_a = ist_mag;
				mul_b = MB_W'(dt_q);
				mneg  = ist_q[MA_W-1];
			end
			ST_MULD: begin
				mul_a = MA_W'(kd_mag);
				mul_b = diff_mag;
				mneg  = kd_q[DATA_W-1] ^ diff[DATA_W];
			end
			default: ;
		endcase
	end

	// scale divides by 1000, derivative by dt*1000 using the held kd*diff magnitude
	assign div_dvd = (state_q == ST_SCALE) ? DVD_W'({er_mag, {ERR_FRAC{1'b0}}})
	                                       : mul_prod[DVD_W-1:0];
	assign div_dvs = (state_q == ST_SCALE) ? ERR_DIV : (DVS_W'(dt_q) * ERR_DIV);

	pidc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pidc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// signed product and its floor shifts
	assign sprod = mneg ? -$signed({1'b0, mul_prod[DVD_W-1:0]}) : $signed({1'b0, mul_prod[DVD_W-1:0]});
	assign p_new = sprod[GAIN_FRAC+MA_W-1:GAIN_FRAC];
	assign step  = sprod[STEP_W:1];

	// integral with clamp at half limits, upper test first
	assign hi_half = out_max_q >>> 1;
	assign lo_half = out_min_q >>> 1;
	assign acc     = (STEP_W+1)'(integ_q) + (STEP_W+1)'(step);
	always_comb begin
		if (acc > hi_half)
			integ_new = hi_half;
		else if (acc < lo_half)
			integ_new = lo_half;
		else
			integ_new = acc[DATA_W-1:0];
	end

	// error scaling, saturated to 32 bits
	always_comb begin
		if (|div_quo[DVD_W-1:DATA_W-1])
			e_new = er_q[DATA_W-1] ? SAT_MIN : SAT_MAX;
		else if (er_q[DATA_W-1])
			e_new = -div_quo[DATA_W-1:0];
		else
			e_new = div_quo[DATA_W-1:0];
	end

	// derivative: truncated quotient, then floor shift and saturate
	assign squo = dneg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign dsh  = squo[DVD_W:GAIN_FRAC];
	assign dtop = dsh[SH_W-1:DATA_W-1];
	always_comb begin
		if (!(&dtop || ~|dtop))
			deriv_new = dsh[SH_W-1] ? SAT_MIN : SAT_MAX;
		else
			deriv_new = dsh[DATA_W-1:0];
	end

	assign sum = SUM_W'(p_q) + SUM_W'(integ_q) + SUM_W'(deriv_q);
	always_comb begin
		if (sum > out_max_q)
			drive_new = out_max_q;
		else if (sum < out_min_q)
			drive_new = out_min_q;
		else
			drive_new = sum[DATA_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			new_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			new_q   <= (state_d != state_q);
		end
	end

	always_comb begin
		state_d  = state_q;
		mul_go   = 1'b0;
		div_go   = 1'b0;
		load_out = 1'b0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !op)
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				div_go = new_q;
				if (div_done)
					state_d = ST_MULP;
			end
			ST_MULP: begin
				mul_go = new_q;
				if (mul_done)
					state_d = first_q ? ST_SUM : ST_MULI;
			end
			ST_MULI: begin
				mul_go = new_q;
				if (mul_done)
					state_d = ST_MULT;
			end
			ST_MULT: begin
				mul_go = new_q;
				if (mul_done)
					state_d = (dt_q == '0) ? ST_SUM : ST_MULD;
			end
			ST_MULD: begin
				mul_go = new_q;
				if (mul_done)
					state_d = ST_DIVD;
			end
			ST_DIVD: begin
				div_go = new_q;
				if (div_done)
					state_d = ST_SUM;
			end
			ST_SUM: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// loop state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			last_q      <= '0;
			deriv_q     <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready && op) begin
				integ_q <= '0;
				last_q  <= '0;
				first_q <= 1'b1;
			end
			if (state_q == ST_MULT && mul_done) begin
				integ_q <= integ_new;
				if (dt_q == '0)
					deriv_q <= '0;
			end
			if (state_q == ST_DIVD && div_done)
				deriv_q <= deriv_new;
			if (load_out) begin
				out_valid_q <= 1'b1;
				last_q      <= e_q;
				first_q     <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			er_q <= error_raw;
			dt_q <= use_fixed_q ? fixed_q : elapsed;
		end
		if (state_q == ST_SCALE && div_done)
			e_q <= e_new;
		if (state_q == ST_MULP && mul_done)
			p_q <= p_new;
		if (state_q == ST_MULI && mul_done)
			ist_q <= p_new;
		if (state_q == ST_MULD && mul_done)
			dneg_q <= mneg;
		if (load_out)
			drive_q <= drive_new;
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	a_mul_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MULP || state_q == ST_MULI ||
		              state_q == ST_MULT || state_q == ST_MULD))
		else $error("multiplier finished outside a multiply step");

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_SCALE || state_q == ST_DIVD))
		else $error("divider finished outside a divide step");

	a_out_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SUM))
		else $error("result raised without passing the sum step");

endmodule

// ===== dv/tb.sv =====
// Testbench for pid_controller_clamped: random and directed loop items, idling on both sides.
// A built-in PID model predicts each drive value, which is checked against the result stream.
// Depends on pidc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
	import pidc_pkg::*;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	localparam int RAND_PHASES    = 6;
	localparam int PHASE_ITEMS    = 150;
	localparam int SETTLE_CYCLES  = 400;
	localparam int HOLD_CYCLES    = 1500;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_REPORTS    = 40;

	typedef struct packed {
		logic                     op;
		logic signed [DATA_W-1:0] err;
		logic [DT_W-1:0]          el;
	} loop_item_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_idx   = '0;
	logic [DATA_W-1:0]        cfg_wdata = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic                     op        = OP_UPDATE;
	logic signed [DATA_W-1:0] error_raw = '0;
	logic [DT_W-1:0]          elapsed   = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] drive;

	loop_item_t               loop_items[$];
	logic signed [DATA_W-1:0] expected_drive[$];
	int items_queued = 0;
	int items_taken  = 0;
	int mismatch_count = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;

	// model copy of the registers and loop state
	int g_kp, g_ki, g_kd, lim_hi, lim_lo;
	bit use_fixed;
	logic [DT_W-1:0] fixed_ivl;
	int integ, last_err, deriv;
	bit first_pending;

	pid_controller_clamped u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.error_raw (error_raw),
		.elapsed   (elapsed),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [DATA_W-1:0] sat_word(longint v);
		if (v > WORD_MAX)
			return WORD_MAX[31:0];
		if (v < WORD_MIN)
			return WORD_MIN[31:0];
		return v[31:0];
	endfunction

	// upper bound is tested first, so with crossed limits a value above the max resolves to the max
	function automatic longint clamp_hi_first(longint v, longint hi, longint lo);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic logic signed [DATA_W-1:0] pid_update(logic signed [DATA_W-1:0] err_raw,
			logic [DT_W-1:0] el);
		longint dt, e, p, acc, q, sum;
		dt = use_fixed ? fixed_ivl : el;
		e = sat_word((longint'(err_raw) * 65536) / 1000);
		p = (longint'(g_kp) * e) >>> 24;
		if (!first_pending) begin
			acc = longint'(integ) + ((((longint'(g_ki) * e) >>> 24) * dt) >>> 1);
			acc = clamp_hi_first(acc, longint'(lim_hi) >>> 1, longint'(lim_lo) >>> 1);
			integ = acc[31:0];
			if (dt == 0) begin
				deriv = 0;
			end else begin
				q = (longint'(g_kd) * (e - longint'(last_err))) / (dt * 1000);
				deriv = sat_word(q >>> 24);
			end
		end else begin
			// first step: keep stored integral and derivative
			first_pending = 1'b0;
		end
		sum = clamp_hi_first(p + longint'(integ) + longint'(deriv), lim_hi, lim_lo);
		last_err = e[31:0];
		return sum[31:0];
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 20);
		return $urandom_range(40, 120);
	endfunction

	function automatic logic [DATA_W-1:0] rand_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;  // about +-2.0
		if (r < 9)
			return $urandom;
		return '0;
	endfunction

	task automatic report_mismatch(string what, logic signed [DATA_W-1:0] got,
			logic signed [DATA_W-1:0] want);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: %s: drive %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_item(logic o, logic signed [DATA_W-1:0] err, logic [DT_W-1:0] el);
		loop_item_t it;
		it.op = o;
		it.err = err;
		it.el = el;
		loop_items.push_back(it);
		items_queued++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every item taken and every result back, then wait out the settle period
	task automatic settle();
		while (items_taken != items_queued || expected_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin
		loop_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_UPDATE;
			error_raw <= '0;
			elapsed <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_ready) begin
		end else if (send_gap != 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (loop_items.size() != 0) begin
			it = loop_items.pop_front();
			in_valid <= 1'b1;
			op <= it.op;
			error_raw <= it.err;
			elapsed <= it.el;
			send_gap <= pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_seen <= 0;
		end else if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			stall_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else begin
			g = ((out_valid && out_ready) || $urandom_range(0, 15) == 0) ? pick_gap() : 0;
			stall_left <= g;
			out_ready <= (g == 0);
		end
	end

	// monitor: checks results, predicts on accepted items, tracks register writes
	always @(posedge clk or negedge arst_n) begin
		logic signed [DATA_W-1:0] want;
		if (!arst_n) begin
			g_kp = 0;
			g_ki = 0;
			g_kd = 0;
			lim_hi = 32'h7FFF_FFFF;
			lim_lo = 32'h8000_0000;
			use_fixed = 1'b0;
			fixed_ivl = FIXED_INTERVAL_RST;
			integ = 0;
			last_err = 0;
			deriv = 0;
			first_pending = 1'b1;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_drive.size() == 0) begin
					report_mismatch("unexpected result", drive, '0);
				end else begin
					want = expected_drive.pop_front();
					if (drive !== want)
						report_mismatch("wrong drive", drive, want);
				end
			end
			if (in_valid && in_ready) begin
				items_taken++;
				if (op == OP_UPDATE) begin
					expected_drive.push_back(pid_update(error_raw, elapsed));
				end else begin
					// clear keeps the derivative
					integ = 0;
					last_err = 0;
					first_pending = 1'b1;
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_KP:             g_kp = cfg_wdata;
					REG_KI:             g_ki = cfg_wdata;
					REG_KD:             g_kd = cfg_wdata;
					REG_OUT_MAX:        lim_hi = cfg_wdata;
					REG_OUT_MIN:        lim_lo = cfg_wdata;
					REG_USE_FIXED:      use_fixed = cfg_wdata[0];
					REG_FIXED_INTERVAL: fixed_ivl = cfg_wdata[DT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int r;
		logic signed [DATA_W-1:0] err;
		logic [DT_W-1:0] el;
		logic [DATA_W-1:0] hi, lo;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// moderate gains, +-100.0 limits, interval from the item
		write_reg(REG_KP, 32'h0100_0000);
		write_reg(REG_KI, 32'h0080_0000);
		write_reg(REG_KD, 32'h0040_0000);
		write_reg(REG_OUT_MAX, 32'h0064_0000);
		write_reg(REG_OUT_MIN, 32'hFF9C_0000);
		write_reg(REG_USE_FIXED, 32'h0);
		write_reg(REG_FIXED_INTERVAL, 32'd40);
		queue_item(OP_UPDATE, 1000, 10);
		queue_item(OP_UPDATE, 5000, 10);
		queue_item(OP_UPDATE, -3000, 0);
		queue_item(OP_UPDATE, 32'h7FFF_FFFF, 16'hFFFF);
		queue_item(OP_UPDATE, 32'h8000_0000, 1);
		queue_item(OP_UPDATE, -1, 1);
		queue_item(OP_UPDATE, 999, 3);
		queue_item(OP_CLEAR, $urandom, 16'($urandom));
		queue_item(OP_UPDATE, 2000, 5);
		queue_item(OP_UPDATE, 2000, 5);
		// drive the integral into both clamps
		repeat (3) queue_item(OP_UPDATE, 300000, 100);
		repeat (3) queue_item(OP_UPDATE, -300000, 100);

		// crossed limits, fixed interval of zero
		settle();
		write_reg(REG_OUT_MAX, 32'hFFFB_0000);
		write_reg(REG_OUT_MIN, 32'h0005_0000);
		write_reg(REG_USE_FIXED, 32'hFFFF_FFFF);
		write_reg(REG_FIXED_INTERVAL, 32'hABCD_0000);
		queue_item(OP_UPDATE, 7000, 16'hFFFF);
		queue_item(OP_UPDATE, -7000, 16'h0);
		queue_item(OP_UPDATE, 0, 16'h1234);

		// extreme gains and limits, longest fixed interval
		settle();
		write_reg(REG_KP, 32'h7FFF_FFFF);
		write_reg(REG_KI, 32'h8000_0000);
		write_reg(REG_KD, 32'h8000_0000);
		write_reg(REG_OUT_MAX, 32'h7FFF_FFFF);
		write_reg(REG_OUT_MIN, 32'h8000_0000);
		write_reg(REG_FIXED_INTERVAL, 32'h0000_FFFF);
		write_reg(REG_UNUSED, $urandom);
		queue_item(OP_UPDATE, 32'h7FFF_FFFF, 0);
		queue_item(OP_UPDATE, 32'h8000_0000, 0);
		queue_item(OP_UPDATE, 32'h8000_0000, 0);
		queue_item(OP_UPDATE, 32'h7FFF_FFFF, 0);
		settle();
		write_reg(REG_KP, 32'h8000_0000);
		write_reg(REG_KI, 32'h7FFF_FFFF);
		write_reg(REG_KD, 32'h7FFF_FFFF);
		write_reg(REG_USE_FIXED, 32'h0);
		queue_item(OP_UPDATE, 32'h8000_0000, 1);
		queue_item(OP_UPDATE, 32'h7FFF_FFFF, 1);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			no_idle = (ph == 3);
			write_reg(REG_KP, rand_gain());
			write_reg(REG_KI, rand_gain());
			write_reg(REG_KD, rand_gain());
			r = $urandom_range(0, 9);
			if (r < 6) begin
				hi = $urandom_range(1, 32'h4000_0000);
				lo = 32'd0 - $urandom_range(1, 32'h4000_0000);
			end else if (r < 9) begin
				hi = $urandom;
				lo = $urandom;
			end else begin
				hi = 32'h7FFF_FFFF;
				lo = 32'h8000_0000;
			end
			write_reg(REG_OUT_MAX, hi);
			write_reg(REG_OUT_MIN, lo);
			write_reg(REG_USE_FIXED, $urandom);
			r = $urandom_range(0, 9);
			el = (r < 7) ? 16'($urandom_range(1, 200)) : (r < 9) ? 16'($urandom) : 16'h0;
			write_reg(REG_FIXED_INTERVAL, {16'($urandom), el});

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 7) begin
					queue_item(OP_CLEAR, $urandom, 16'($urandom));
				end else begin
					r = $urandom_range(0, 99);
					if (r < 70)
						err = $urandom_range(0, 600000) - 300000;
					else if (r < 95)
						err = $urandom;
					else
						err = r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
					r = $urandom_range(0, 99);
					if (r < 10)
						el = '0;
					else if (r < 75)
						el = 16'($urandom_range(1, 100));
					else
						el = 16'($urandom);
					queue_item(OP_UPDATE, err, el);
				end
			end
			// receiver holds off while the sender keeps offering
			if (ph == 1)
				hold_ask++;
		end

		settle();
		if (mismatch_count == 0 && expected_drive.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
